>>> src/vnc_pkg.sv
package vnc_pkg;

  localparam int CompW = 32;
  localparam int LimW = 31;
  localparam int NumW = 62;
  localparam int SqrtSteps = 16;
  localparam int DivSteps = 16;

  localparam logic [LimW-1:0] ONE_Q16 = 31'd65536;
  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  // register indexes
  localparam logic REG_LOW = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  typedef enum logic {
    OP_NORMALIZE = 1'b0,
    OP_CLAMP = 1'b1
  } op_t;

  // item in the square root chain
  typedef struct packed {
    logic valid;
    logic [3:0][CompW-1:0] comp;
    logic scale;
    logic [3:0][NumW-1:0] num;
    logic [63:0] src;
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // item in the divider chain
  typedef struct packed {
    logic valid;
    logic [3:0][CompW-1:0] comp;
    logic scale;
    logic [31:0] mag;
    logic [3:0] ovf;
    logic [3:0][31:0] rem;
    logic [3:0][31:0] numlo;
    logic [3:0][31:0] quo;
  } div_t;

endpackage

>>> src/vnc_front.sv
module vnc_front
  import vnc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_beat,
  input  logic op,
  input  logic [3:0][CompW-1:0] comp,
  input  logic [LimW-1:0] low_limit,
  input  logic [LimW-1:0] high_limit,
  input  logic [61:0] low_sq,
  input  logic [61:0] high_sq,
  output sqrt_t stage
);

  // stage one: squares of magnitudes
  logic s1_valid;
  logic s1_op;
  logic [3:0][CompW-1:0] s1_comp;
  logic [3:0][63:0] s1_sq;
  logic [3:0][31:0] absv;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      absv[i] = comp[i][31] ? (~comp[i] + 32'd1) : comp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_beat;
      s1_op <= op;
      s1_comp <= comp;
      for (int i = 0; i < 4; i++) begin
        s1_sq[i] <= {32'd0, absv[i]} * {32'd0, absv[i]};
      end
    end
  end

  // stage two: saturating sum of squares
  logic s2_valid;
  logic s2_op;
  logic [3:0][CompW-1:0] s2_comp;
  logic [63:0] s2_sum;
  logic [64:0] sum_full;

  assign sum_full = {1'b0, s1_sq[0]} + {1'b0, s1_sq[1]} + {1'b0, s1_sq[2]}
                  + {1'b0, s1_sq[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s2_op <= s1_op;
      s2_comp <= s1_comp;
      s2_sum <= sum_full[64] ? {64{1'b1}} : sum_full[63:0];
    end
  end

  // stage three: pick the scale factor
  logic s3_valid;
  logic s3_scale;
  logic [LimW-1:0] s3_factor;
  logic [3:0][CompW-1:0] s3_comp;
  logic [63:0] s3_sum;
  logic scale_next;
  logic [LimW-1:0] factor_next;

  always_comb begin
    scale_next = 1'b0;
    factor_next = ONE_Q16;
    if (op_t'(s2_op) == OP_NORMALIZE) begin
      scale_next = (s2_sum != 64'd0) && (s2_sum != ONE_Q32);
    end else if (s2_sum < {2'b00, low_sq}) begin
      scale_next = (s2_sum != 64'd0);
      factor_next = low_limit;
    end else if (s2_sum > {2'b00, high_sq}) begin
      scale_next = 1'b1;
      factor_next = high_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
      s3_scale <= scale_next;
      s3_factor <= factor_next;
      s3_comp <= s2_comp;
      s3_sum <= s2_sum;
    end
  end

  // stage four: numerators |comp| * factor, start of square root
  logic [3:0][31:0] abs3;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      abs3[i] = s3_comp[i][31] ? (~s3_comp[i] + 32'd1) : s3_comp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= s3_valid;
      stage.comp <= s3_comp;
      stage.scale <= s3_scale;
      for (int i = 0; i < 4; i++) begin
        stage.num[i] <= NumW'({31'd0, abs3[i]} * {32'd0, s3_factor});
      end
      stage.src <= s3_sum;
      stage.rem <= 36'd0;
      stage.root <= 32'd0;
    end
  end

endmodule

>>> src/vnc_sqrt_step.sv
module vnc_sqrt_step
  import vnc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  sqrt_t in_stage,
  output sqrt_t stage
);

  sqrt_t stage_next;
  logic [35:0] r;
  logic [35:0] t;
  logic [31:0] q;
  logic [63:0] sr;

  // two root digits per stage
  always_comb begin
    stage_next = in_stage;
    r = in_stage.rem;
    q = in_stage.root;
    sr = in_stage.src;
    t = 36'd0;
    for (int k = 0; k < 2; k++) begin
      r = {r[33:0], sr[63:62]};
      sr = {sr[61:0], 2'b00};
      t = {2'b00, q, 2'b01};
      if (r >= t) begin
        r = r - t;
        q = {q[30:0], 1'b1};
      end else begin
        q = {q[30:0], 1'b0};
      end
    end
    stage_next.rem = r;
    stage_next.root = q;
    stage_next.src = sr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage <= stage_next;
    end
  end

endmodule

>>> src/vnc_div_step.sv
module vnc_div_step
  import vnc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  div_t in_stage,
  output div_t stage
);

  div_t stage_next;
  logic [32:0] r33;
  logic [31:0] r;
  logic [31:0] nl;
  logic [31:0] q;

  // two quotient bits per lane per stage
  always_comb begin
    stage_next = in_stage;
    r33 = 33'd0;
    for (int i = 0; i < 4; i++) begin
      r = in_stage.rem[i];
      nl = in_stage.numlo[i];
      q = in_stage.quo[i];
      for (int k = 0; k < 2; k++) begin
        r33 = {r, nl[31]};
        nl = {nl[30:0], 1'b0};
        if (r33 >= {1'b0, in_stage.mag}) begin
          r33 = r33 - {1'b0, in_stage.mag};
          q = {q[30:0], 1'b1};
        end else begin
          q = {q[30:0], 1'b0};
        end
        r = r33[31:0];
      end
      stage_next.rem[i] = r;
      stage_next.numlo[i] = nl;
      stage_next.quo[i] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage <= stage_next;
    end
  end

endmodule

>>> src/vector4_normalize_clamp.sv
// pipeline: 4 front stages, 16 root stages, 16 divide stages and 1 output register
// throughput: one vector per cycle; a stalled output freezes the whole pipeline in place
// the square root and the four dividers each resolve two bits per stage
// reset: synchronous, active high; clears all valid bits, low_limit to 0, high_limit to 1.0
module vector4_normalize_clamp
  import vnc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic op,
  input  logic signed [31:0] comp_a,
  input  logic signed [31:0] comp_b,
  input  logic signed [31:0] comp_c,
  input  logic signed [31:0] comp_d,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] res_a,
  output logic signed [31:0] res_b,
  output logic signed [31:0] res_c,
  output logic signed [31:0] res_d,
  output logic was_scaled,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [30:0] cfg_data
);

  logic en;
  logic [LimW-1:0] low_limit;
  logic [LimW-1:0] high_limit;
  logic [61:0] low_sq;
  logic [61:0] high_sq;
  logic [3:0][CompW-1:0] comp;

  // pipeline advances unless the output beat is held
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign comp = {comp_d, comp_c, comp_b, comp_a};

  // limit registers and their squares
  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit <= '0;
      high_limit <= ONE_Q16;
      low_sq <= '0;
      high_sq <= ONE_Q32[61:0];
    end else begin
      if (cfg_we && cfg_index == REG_LOW) begin
        low_limit <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_HIGH) begin
        high_limit <= cfg_data;
      end
      low_sq <= {31'd0, low_limit} * {31'd0, low_limit};
      high_sq <= {31'd0, high_limit} * {31'd0, high_limit};
    end
  end

  // front stages
  sqrt_t sq_chain [SqrtSteps+1];

  vnc_front u_front (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_beat(in_valid),
    .op(op),
    .comp(comp),
    .low_limit(low_limit),
    .high_limit(high_limit),
    .low_sq(low_sq),
    .high_sq(high_sq),
    .stage(sq_chain[0])
  );

  // square root chain
  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    vnc_sqrt_step u_step (
      .clk(clk),
      .rst(rst),
      .en(en),
      .in_stage(sq_chain[g]),
      .stage(sq_chain[g+1])
    );
  end

  // divider setup: overflow check on the upper numerator bits
  div_t dv_chain [DivSteps+1];
  sqrt_t sq_last;
  logic [31:0] hi;

  assign sq_last = sq_chain[SqrtSteps];

  always_comb begin
    dv_chain[0].valid = sq_last.valid;
    dv_chain[0].comp = sq_last.comp;
    dv_chain[0].scale = sq_last.scale;
    dv_chain[0].mag = sq_last.root;
    hi = 32'd0;
    for (int i = 0; i < 4; i++) begin
      hi = {2'b00, sq_last.num[i][61:32]};
      dv_chain[0].ovf[i] = (hi >= sq_last.root);
      dv_chain[0].rem[i] = hi;
      dv_chain[0].numlo[i] = sq_last.num[i][31:0];
      dv_chain[0].quo[i] = 32'd0;
    end
  end

  // divider chain
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    vnc_div_step u_step (
      .clk(clk),
      .rst(rst),
      .en(en),
      .in_stage(dv_chain[g]),
      .stage(dv_chain[g+1])
    );
  end

  // sign, saturation and output register
  div_t dv_last;
  logic [3:0][31:0] res_next;

  assign dv_last = dv_chain[DivSteps];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!dv_last.scale) begin
        res_next[i] = dv_last.comp[i];
      end else if (dv_last.ovf[i]) begin
        res_next[i] = dv_last.comp[i][31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (!dv_last.comp[i][31]) begin
        res_next[i] = dv_last.quo[i][31] ? 32'h7FFF_FFFF : dv_last.quo[i];
      end else begin
        res_next[i] = (dv_last.quo[i] > 32'h8000_0000) ? 32'h8000_0000
                    : (~dv_last.quo[i] + 32'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_a <= res_next[0];
      res_b <= res_next[1];
      res_c <= res_next[2];
      res_d <= res_next[3];
      was_scaled <= dv_last.scale;
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import vnc_pkg::*;

  // one vector beat in, one result beat out
  typedef struct {
    op_t op;
    logic signed [31:0] comp [4];
  } vec_beat_t;

  typedef struct {
    logic signed [31:0] comp [4];
    logic scaled;
  } res_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = 1'b0;
  logic signed [31:0] comp_a = '0;
  logic signed [31:0] comp_b = '0;
  logic signed [31:0] comp_c = '0;
  logic signed [31:0] comp_d = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] res_a, res_b, res_c, res_d;
  logic was_scaled;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_LOW;
  logic [30:0] cfg_data = '0;

  vec_beat_t pending_vecs[$];
  res_beat_t expected_res[$];
  logic [30:0] lim_low = 31'd0;
  logic [30:0] lim_high = 31'd65536;
  int errors = 0;
  bit stim_done = 1'b0;
  bit quiet = 1'b0;
  bit in_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  vector4_normalize_clamp i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .comp_a(comp_a), .comp_b(comp_b), .comp_c(comp_c), .comp_d(comp_d),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_a(res_a), .res_b(res_b), .res_c(res_c), .res_d(res_d),
    .was_scaled(was_scaled),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // integer square root, floor
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // normalize or clamp one vector
  function automatic res_beat_t scale_vector(vec_beat_t v);
    res_beat_t r;
    logic [63:0] sumsq, sq, mag;
    logic [64:0] acc;
    longint signed c, factor, q;
    logic [63:0] lo2, hi2;
    sumsq = 0;
    factor = 0;
    r.scaled = 1'b0;
    for (int i = 0; i < 4; i++) begin
      c = v.comp[i];
      if (c < 0) c = -c;
      sq = c * c;
      acc = {1'b0, sumsq} + {1'b0, sq};
      sumsq = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
    end
    lo2 = 64'(lim_low) * 64'(lim_low);
    hi2 = 64'(lim_high) * 64'(lim_high);
    if (v.op == OP_NORMALIZE) begin
      if (sumsq != 0 && sumsq != ONE_Q32) begin
        r.scaled = 1'b1;
        factor = 65536;
      end
    end else if (sumsq < lo2) begin
      if (sumsq != 0) begin
        r.scaled = 1'b1;
        factor = lim_low;
      end
    end else if (sumsq > hi2) begin
      r.scaled = 1'b1;
      factor = lim_high;
    end
    mag = floor_sqrt(sumsq);
    for (int i = 0; i < 4; i++) begin
      if (r.scaled) begin
        c = v.comp[i];
        q = (c * factor) / longint'(mag);
        if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
        if (q < -64'sh8000_0000) q = -64'sh8000_0000;
        r.comp[i] = q[31:0];
      end else begin
        r.comp[i] = v.comp[i];
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 131072) - 65536;
      1: return $urandom_range(0, 8) << 16;
      2: return $signed($urandom) >>> $urandom_range(0, 31);
      3: return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_vec(op_t o, int a, int b, int c, int d);
    vec_beat_t v;
    v.op = o;
    v.comp[0] = a;
    v.comp[1] = b;
    v.comp[2] = c;
    v.comp[3] = d;
    pending_vecs.push_back(v);
  endtask

  // wait for the pipeline to drain, then write a limit
  task automatic set_limit(logic idx, logic [30:0] val);
    wait (pending_vecs.size() == 0 && expected_res.size() == 0);
    repeat (45) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LOW) lim_low = val;
    else lim_high = val;
  endtask

  task automatic push_random(int n);
    for (int k = 0; k < n; k++)
      push_vec(op_t'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  // stimulus
  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    // directed: zero, unit, overflow, saturation, extremes
    push_vec(OP_NORMALIZE, 0, 0, 0, 0);
    push_vec(OP_NORMALIZE, 65536, 0, 0, 0);
    push_vec(OP_NORMALIZE, 0, 0, 0, -65536);
    push_vec(OP_NORMALIZE, 32768, 32768, 32768, 32768);
    push_vec(OP_NORMALIZE, 1, 0, 0, 0);
    push_vec(OP_NORMALIZE, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
             -32'sh8000_0000);
    push_vec(OP_NORMALIZE, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF, 5);
    push_vec(OP_CLAMP, 0, 0, 0, 0);
    push_vec(OP_CLAMP, 1000, -2000, 0, 3);
    push_vec(OP_CLAMP, 65536, 0, 0, 0);
    push_vec(OP_CLAMP, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_vec(OP_CLAMP, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
             -32'sh8000_0000);
    push_vec(OP_CLAMP, -1, 1, -1, 1);
    set_limit(REG_LOW, 31'd32768);
    push_vec(OP_CLAMP, 0, 0, 0, 0);
    push_vec(OP_CLAMP, 1, -1, 0, 0);
    push_vec(OP_CLAMP, 40000, 0, 0, 0);
    push_vec(OP_CLAMP, 0, 0, 200000, 0);
    // crossed limits, then extremes
    set_limit(REG_HIGH, 31'd100);
    push_vec(OP_CLAMP, 1000, 0, 0, 0);
    push_vec(OP_CLAMP, 0, 50000, 0, 0);
    set_limit(REG_LOW, 31'h7FFF_FFFF);
    set_limit(REG_HIGH, 31'h7FFF_FFFF);
    push_vec(OP_CLAMP, 1, 0, 0, 0);
    push_vec(OP_CLAMP, -3, 2, 65536, 0);
    push_random(150);
    set_limit(REG_LOW, 31'd0);
    set_limit(REG_HIGH, 31'd0);
    push_random(150);
    set_limit(REG_LOW, 31'($urandom_range(0, 200000)));
    set_limit(REG_HIGH, 31'($urandom_range(0, 400000)));
    push_random(200);
    set_limit(REG_LOW, 31'($urandom));
    set_limit(REG_HIGH, 31'($urandom));
    push_random(200);
    set_limit(REG_LOW, 31'd65536);
    set_limit(REG_HIGH, 31'd131072);
    quiet = 1'b1;
    push_random(230);
    wait (pending_vecs.size() == 0);
    stim_done = 1'b1;
  end

  // driver: beats change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (pending_vecs.size() > 0) begin
        in_valid <= 1'b1;
        op <= pending_vecs[0].op;
        comp_a <= pending_vecs[0].comp[0];
        comp_b <= pending_vecs[0].comp[1];
        comp_c <= pending_vecs[0].comp[2];
        comp_d <= pending_vecs[0].comp[3];
      end else begin
        in_valid <= 1'b0;
      end
    end
    // receiver stall bursts
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    vec_beat_t v;
    res_beat_t e;
    if (!rst && in_valid && !in_stall) begin
      v = pending_vecs.pop_front();
      in_taken = 1'b1;
      expected_res.push_back(scale_vector(v));
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (res_a !== e.comp[0]) begin
          $error("res_a expected %0d actual %0d", e.comp[0], res_a); errors++;
        end
        if (res_b !== e.comp[1]) begin
          $error("res_b expected %0d actual %0d", e.comp[1], res_b); errors++;
        end
        if (res_c !== e.comp[2]) begin
          $error("res_c expected %0d actual %0d", e.comp[2], res_c); errors++;
        end
        if (res_d !== e.comp[3]) begin
          $error("res_d expected %0d actual %0d", e.comp[3], res_d); errors++;
        end
        if (was_scaled !== e.scaled) begin
          $error("was_scaled expected %0d actual %0d", e.scaled, was_scaled); errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done && !in_valid);
    wait (expected_res.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> vector4_normalize_clamp.f
src/vnc_pkg.sv
src/vnc_front.sv
src/vnc_sqrt_step.sv
src/vnc_div_step.sv
src/vector4_normalize_clamp.sv
dv/testbench.sv
